/* design/mptg_pkg.sv */
`default_nettype none

package mptg_pkg;

    // Field widths of the stream payloads
    localparam int KIND_W = 3;
    localparam int CHAN_W = 3;
    localparam int DUR_W  = 16;
    localparam int CNT_W  = 14;
    localparam int GATE_W = 3;
    localparam int MODE_W = 2;
    localparam int STAT_W = 2;

    // Range limits and reset values
    localparam logic [DUR_W-1:0] DUR_MIN     = 16'd1;
    localparam logic [DUR_W-1:0] DUR_MAX     = 16'd60000;
    localparam logic [CNT_W-1:0] CNT_MIN     = 14'd1;
    localparam logic [CNT_W-1:0] CNT_MAX     = 14'd10000;
    localparam logic [DUR_W-1:0] DUR_RESET   = 16'd100;
    localparam logic [DUR_W-1:0] ELAPSED_MAX = 16'hFFFF;

    // Kind of an input transaction; codes five to seven carry no command
    typedef enum logic [KIND_W-1:0] {
        KIND_TICK      = 3'd0,
        KIND_SET_OFF   = 3'd1,
        KIND_SET_DC    = 3'd2,
        KIND_SET_PULSE = 3'd3,
        KIND_STOP_ALL  = 3'd4
    } t_kind;

    typedef enum logic [MODE_W-1:0] {
        MODE_OFF   = 2'd0,
        MODE_DC    = 2'd1,
        MODE_PULSE = 2'd2,
        MODE_TRAIN = 2'd3
    } t_mode;

    typedef enum logic [STAT_W-1:0] {
        STATUS_OK           = 2'd0,
        STATUS_BAD_CHANNEL  = 2'd1,
        STATUS_BAD_DURATION = 2'd2,
        STATUS_BAD_COUNT    = 2'd3
    } t_status;

    // Decoded command, shared by all channels
    typedef struct packed {
        logic              ch_valid;
        logic [CHAN_W-1:0] ch_idx;
        t_status           status;
        logic              tick;
        logic              stop_all;
        logic              do_off;
        logic              do_dc;
        logic              do_pulse;
    } t_dec;

    // Command as seen by one channel
    typedef struct packed {
        logic             tick;
        logic             stop_all;
        logic             set_off;
        logic             set_dc;
        logic             set_pulse;
        logic [DUR_W-1:0] duration;
        logic [CNT_W-1:0] count;
    } t_chan_cmd;

endpackage

`default_nettype wire

/* design/mptg_cmd_dec.sv */
`default_nettype none

module mptg_cmd_dec #(
    parameter int CHANNELS = 3
) (
    input  wire logic [mptg_pkg::KIND_W-1:0] i_kind,
    input  wire logic [mptg_pkg::CHAN_W-1:0] i_channel,
    input  wire logic [mptg_pkg::DUR_W-1:0]  i_duration,
    input  wire logic [mptg_pkg::CNT_W-1:0]  i_count,
    output mptg_pkg::t_dec                   o_dec
);

    logic ch_valid;

    // A channel number is valid from one up to the number of channels.
    assign ch_valid = (i_channel != '0) && (32'(i_channel) <= 32'(CHANNELS));

    // Range checks in order: channel, then duration, then count.
    always_comb begin
        o_dec          = '0;
        o_dec.ch_valid = ch_valid;
        o_dec.ch_idx   = ch_valid ? (i_channel - mptg_pkg::CHAN_W'(1)) : '0;
        o_dec.status   = mptg_pkg::STATUS_OK;
        case (mptg_pkg::t_kind'(i_kind))
            mptg_pkg::KIND_TICK: begin
                o_dec.tick = 1'b1;
            end
            mptg_pkg::KIND_SET_OFF: begin
                if (!ch_valid) begin
                    o_dec.status = mptg_pkg::STATUS_BAD_CHANNEL;
                end else begin
                    o_dec.do_off = 1'b1;
                end
            end
            mptg_pkg::KIND_SET_DC: begin
                if (!ch_valid) begin
                    o_dec.status = mptg_pkg::STATUS_BAD_CHANNEL;
                end else begin
                    o_dec.do_dc = 1'b1;
                end
            end
            mptg_pkg::KIND_SET_PULSE: begin
                if (!ch_valid) begin
                    o_dec.status = mptg_pkg::STATUS_BAD_CHANNEL;
                end else if (i_duration < mptg_pkg::DUR_MIN ||
                             i_duration > mptg_pkg::DUR_MAX) begin
                    o_dec.status = mptg_pkg::STATUS_BAD_DURATION;
                end else if (i_count < mptg_pkg::CNT_MIN ||
                             i_count > mptg_pkg::CNT_MAX) begin
                    o_dec.status = mptg_pkg::STATUS_BAD_COUNT;
                end else begin
                    o_dec.do_pulse = 1'b1;
                end
            end
            mptg_pkg::KIND_STOP_ALL: begin
                o_dec.stop_all = 1'b1;
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

/* design/mptg_chan.sv */
`default_nettype none

module mptg_chan (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_en,
    input  wire mptg_pkg::t_chan_cmd        i_cmd,
    output logic                            o_level,
    output mptg_pkg::t_mode                 o_mode,
    output logic [mptg_pkg::CNT_W-1:0]      o_remaining
);

    mptg_pkg::t_mode                 r_mode;
    logic [mptg_pkg::DUR_W-1:0]      r_duration;
    logic [mptg_pkg::CNT_W-1:0]      r_remaining;
    logic [mptg_pkg::DUR_W-1:0]      r_elapsed;
    logic                            r_in_gap;

    mptg_pkg::t_mode                 n_mode;
    logic [mptg_pkg::DUR_W-1:0]      n_duration;
    logic [mptg_pkg::CNT_W-1:0]      n_remaining;
    logic [mptg_pkg::DUR_W-1:0]      n_elapsed;
    logic                            n_in_gap;
    logic                            n_level;

    // Values after the tick and the command, before the phase rules
    mptg_pkg::t_mode                 cmd_mode;
    logic [mptg_pkg::CNT_W-1:0]      cmd_remaining;
    logic [mptg_pkg::DUR_W-1:0]      cmd_elapsed;
    logic                            cmd_in_gap;
    logic                            in_high;

    // Tick and command stage.
    always_comb begin
        cmd_mode      = r_mode;
        cmd_remaining = r_remaining;
        cmd_elapsed   = r_elapsed;
        cmd_in_gap    = r_in_gap;
        n_duration    = r_duration;
        if (i_cmd.tick && r_elapsed != mptg_pkg::ELAPSED_MAX) begin
            cmd_elapsed = r_elapsed + mptg_pkg::DUR_W'(1);
        end
        if (i_cmd.stop_all || i_cmd.set_off || i_cmd.set_dc) begin
            cmd_mode      = i_cmd.set_dc ? mptg_pkg::MODE_DC : mptg_pkg::MODE_OFF;
            cmd_remaining = '0;
            cmd_in_gap    = 1'b0;
        end
        if (i_cmd.set_pulse) begin
            cmd_mode      = (i_cmd.count <= mptg_pkg::CNT_MIN) ? mptg_pkg::MODE_PULSE
                                                               : mptg_pkg::MODE_TRAIN;
            n_duration    = i_cmd.duration;
            cmd_remaining = i_cmd.count;
            cmd_elapsed   = '0;
            cmd_in_gap    = 1'b0;
        end
    end

    assign in_high = (cmd_elapsed < n_duration);

    // Phase rules.
    always_comb begin
        n_mode      = cmd_mode;
        n_remaining = cmd_remaining;
        n_elapsed   = cmd_elapsed;
        n_in_gap    = cmd_in_gap;
        n_level     = 1'b0;
        case (cmd_mode)
            mptg_pkg::MODE_DC: begin
                n_level = 1'b1;
            end
            mptg_pkg::MODE_PULSE: begin
                if (in_high) begin
                    n_level = 1'b1;
                end else begin
                    n_mode      = mptg_pkg::MODE_OFF;
                    n_remaining = '0;
                end
            end
            mptg_pkg::MODE_TRAIN: begin
                if (cmd_remaining == '0) begin
                    n_mode   = mptg_pkg::MODE_OFF;
                    n_in_gap = 1'b0;
                end else if (cmd_in_gap) begin
                    // End of the gap restarts the high phase at once.
                    if (!in_high) begin
                        n_in_gap  = 1'b0;
                        n_elapsed = '0;
                        n_level   = (n_duration != '0);
                    end
                end else if (in_high) begin
                    n_level = 1'b1;
                end else begin
                    n_remaining = cmd_remaining - mptg_pkg::CNT_W'(1);
                    if (cmd_remaining == mptg_pkg::CNT_W'(1)) begin
                        n_mode   = mptg_pkg::MODE_OFF;
                        n_in_gap = 1'b0;
                    end else begin
                        n_in_gap  = 1'b1;
                        n_elapsed = '0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Channel state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= mptg_pkg::MODE_OFF;
            r_duration  <= mptg_pkg::DUR_RESET;
            r_remaining <= '0;
            r_elapsed   <= '0;
            r_in_gap    <= 1'b0;
        end else if (i_en) begin
            r_mode      <= n_mode;
            r_duration  <= n_duration;
            r_remaining <= n_remaining;
            r_elapsed   <= n_elapsed;
            r_in_gap    <= n_in_gap;
        end
    end

    assign o_level     = n_level;
    assign o_mode      = n_mode;
    assign o_remaining = n_remaining;

endmodule

`default_nettype wire

/* design/multichannel_pulse_train_gen.sv */
// Channel   Direction  Signals                         Content
// s_axis    in         tvalid, tready, tdata, tuser    tuser: kind; tdata: command
// m_axis    out        tvalid, tready, tdata           tdata: gates, status, mode, pulses
//
// Every transaction gives one result: it waits in the input register, is loaded into
// the result register once that register is free and is held there until taken;
// one transaction is taken per cycle while the output does not stall. All channel
// counters are updated together as a transaction moves between the two registers.
// Reset is synchronous and empties both registers; a stall on the output holds the
// result and, once the input register is full, holds s_axis_tready low.
`default_nettype none

module multichannel_pulse_train_gen #(
    parameter int CHANNELS = 3
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [2:0] channel, [18:3] duration, [32:19] pulse_count, [39:33] zero
    input  wire logic [39:0] s_axis_tdata,
    // [2:0] kind
    input  wire logic [2:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [2:0] gate_levels, [4:3] status, [6:5] channel_mode, [20:7] pulses_left,
    // [23:21] zero
    output logic [23:0]      m_axis_tdata
);

    localparam int GW = mptg_pkg::GATE_W;

    logic                            r_in_valid;
    logic [mptg_pkg::KIND_W-1:0]     r_kind;
    logic [mptg_pkg::CHAN_W-1:0]     r_channel;
    logic [mptg_pkg::DUR_W-1:0]      r_duration;
    logic [mptg_pkg::CNT_W-1:0]      r_count;

    logic                            r_out_valid;
    logic [GW-1:0]                   r_out_gates;
    mptg_pkg::t_status               r_out_status;
    mptg_pkg::t_mode                 r_out_mode;
    logic [mptg_pkg::CNT_W-1:0]      r_out_pulses;

    logic                            move;
    logic                            in_accept;
    mptg_pkg::t_dec                  dec;
    logic [CHANNELS-1:0]             ch_level;
    mptg_pkg::t_mode                 ch_mode [CHANNELS];
    logic [mptg_pkg::CNT_W-1:0]      ch_remaining [CHANNELS];
    logic [GW+CHANNELS-1:0]          gates_padded;
    mptg_pkg::t_mode                 sel_mode;
    logic [mptg_pkg::CNT_W-1:0]      sel_remaining;

    // Handshake: the held transaction moves on when the result register is free.
    assign move          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || move;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (move) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_kind     <= s_axis_tuser;
            r_channel  <= s_axis_tdata[2:0];
            r_duration <= s_axis_tdata[18:3];
            r_count    <= s_axis_tdata[32:19];
        end
    end

    // Command decode and range checks.
    mptg_cmd_dec #(
        .CHANNELS (CHANNELS)
    ) u_dec (
        .i_kind     (r_kind),
        .i_channel  (r_channel),
        .i_duration (r_duration),
        .i_count    (r_count),
        .o_dec      (dec)
    );

    // One state slice per channel.
    for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
        mptg_pkg::t_chan_cmd cmd;
        logic                hit;

        assign hit           = (dec.ch_idx == mptg_pkg::CHAN_W'(c));
        assign cmd.tick      = dec.tick;
        assign cmd.stop_all  = dec.stop_all;
        assign cmd.set_off   = dec.do_off && hit;
        assign cmd.set_dc    = dec.do_dc && hit;
        assign cmd.set_pulse = dec.do_pulse && hit;
        assign cmd.duration  = r_duration;
        assign cmd.count     = r_count;

        mptg_chan u_chan (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_en        (move),
            .i_cmd       (cmd),
            .o_level     (ch_level[c]),
            .o_mode      (ch_mode[c]),
            .o_remaining (ch_remaining[c])
        );
    end

    // Only the lowest channels fit into the gate field.
    assign gates_padded = {{GW{1'b0}}, ch_level};

    // Mode and pulse count of the addressed channel.
    always_comb begin
        sel_mode      = mptg_pkg::MODE_OFF;
        sel_remaining = '0;
        for (int c = 0; c < CHANNELS; c++) begin
            if (dec.ch_valid && dec.ch_idx == mptg_pkg::CHAN_W'(c)) begin
                sel_mode      = ch_mode[c];
                sel_remaining = ch_remaining[c];
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (move) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_out_gates  <= gates_padded[GW-1:0];
            r_out_status <= dec.status;
            r_out_mode   <= sel_mode;
            r_out_pulses <= sel_remaining;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out_pulses, r_out_mode, r_out_status, r_out_gates};

endmodule

`default_nettype wire

/* design/mptg_chk.sv */
`default_nettype none

module mptg_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_tvalid,
    input wire logic        i_s_tready,
    input wire logic        i_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [23:0] i_m_tdata
);

    logic [1:0]  out_status;
    logic [1:0]  out_mode;
    logic [13:0] out_pulses;

    assign out_status = i_m_tdata[4:3];
    assign out_mode   = i_m_tdata[6:5];
    assign out_pulses = i_m_tdata[20:7];

    // After reset the block is empty and ready for a transaction.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_tvalid && i_s_tready)
        else $error("block not empty after reset");

    // A stalled result holds.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata))
        else $error("stalled result changed");

    // An accepted transaction shows a valid result once it has passed the input and result registers.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && i_s_tready |-> ##2 i_m_tvalid)
        else $error("no result two cycles after acceptance");

    // A bad channel number reports no mode and no pulses.
    a_bad_channel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && out_status == mptg_pkg::STATUS_BAD_CHANNEL
        |-> out_mode == mptg_pkg::MODE_OFF && out_pulses == '0)
        else $error("bad channel result carries channel data");

    // Pulse count agrees with the reported mode.
    a_mode_pulses: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |->
        ((out_mode == mptg_pkg::MODE_PULSE) -> (out_pulses == 14'd1)) &&
        ((out_mode == mptg_pkg::MODE_TRAIN) -> (out_pulses != '0)) &&
        ((out_mode == mptg_pkg::MODE_OFF || out_mode == mptg_pkg::MODE_DC)
            -> (out_pulses == '0)))
        else $error("pulse count does not match mode");

endmodule

bind multichannel_pulse_train_gen mptg_chk u_mptg_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (s_axis_tvalid),
    .i_s_tready (s_axis_tready),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata)
);

`default_nettype wire
